>>> src/assert_macros.svh
// Assertion macros for the clock display design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset.
`define SCSS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define SCSS_ASSERT_IMPLIES(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`else

`define SCSS_ASSERT_ALWAYS(lbl, cond, msg)
`define SCSS_ASSERT_IMPLIES(lbl, trig, cons, msg)

`endif

`endif

>>> src/scss_pkg.sv
// Types, constants and the digit decoder for the clock display.
package scss_pkg;

  localparam int unsigned TickWidth = 12;
  localparam logic [TickWidth-1:0] TicksPerSecondReset = 12'd250;

  localparam logic [4:0] HoursMax   = 5'd23;
  localparam logic [5:0] MinutesMax = 6'd59;
  localparam logic [5:0] SecondsMax = 6'd59;

  localparam logic [7:0] SeparatorPattern = 8'h80;

  // Scan positions that carry a digit; the others show the separator.
  localparam logic [2:0] PosHourTens   = 3'd0;
  localparam logic [2:0] PosHourUnits  = 3'd1;
  localparam logic [2:0] PosMinTens    = 3'd3;
  localparam logic [2:0] PosMinUnits   = 3'd4;
  localparam logic [2:0] PosSecTens    = 3'd6;
  localparam logic [2:0] PosSecUnits   = 3'd7;

  typedef struct packed {
    logic btn_direction_n;
    logic btn_second_n;
    logic btn_minute_n;
    logic btn_hour_n;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digit_select_n;
    logic [7:0] segments;
    logic       direction_led;
  } out_item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_t;

  // Seven-segment pattern for a decimal digit, blank for other codes.
  function automatic logic [7:0] digit_pattern(input logic [3:0] v);
    logic [7:0] p;
    unique case (v)
      4'd0:    p = 8'h3f;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5b;
      4'd3:    p = 8'h4f;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6d;
      4'd6:    p = 8'h7d;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7f;
      4'd9:    p = 8'h6f;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

>>> src/scss_time_step.sv
// Next time of day and adjust direction for a sampling tick.
module scss_time_step
  import scss_pkg::*;
(
  input  time_t    cur,
  input  logic     adjust_down,
  input  in_item_t btn,
  output time_t    nxt,
  output logic     adjust_down_next
);

  logic signed [7:0] step;
  logic signed [7:0] s0, m0, h0;
  logic signed [7:0] s1, m1, h1;
  logic signed [7:0] s2, m2, h2;
  logic signed [7:0] s3, m3, h3;
  logic signed [7:0] s4, m4, h4;

  always_comb begin
    // Toggle direction first; the step uses the new direction
    adjust_down_next = adjust_down ^ ~btn.btn_direction_n;
    step = adjust_down_next ? -8'sd1 : 8'sd1;

    s0 = $signed({2'b00, cur.seconds});
    m0 = $signed({2'b00, cur.minutes});
    h0 = $signed({3'b000, cur.hours});

    // Apply pressed step buttons, then advance one second
    s1 = (btn.btn_second_n ? s0 : s0 + step) + 8'sd1;
    m1 = btn.btn_minute_n ? m0 : m0 + step;
    h1 = btn.btn_hour_n ? h0 : h0 + step;

    // Overflow: carry upward
    if (s1 > 8'sd59) begin
      s2 = 8'sd0;
      m2 = m1 + 8'sd1;
    end else begin
      s2 = s1;
      m2 = m1;
    end
    if (m2 > 8'sd59) begin
      m3 = 8'sd0;
      h2 = h1 + 8'sd1;
    end else begin
      m3 = m2;
      h2 = h1;
    end
    h3 = (h2 > 8'sd23) ? 8'sd0 : h2;

    // Underflow: borrow downward
    if (s2 < 8'sd0) begin
      s3 = 8'sd59;
      m4 = m3 - 8'sd1;
    end else begin
      s3 = s2;
      m4 = m3;
    end
    if (m4 < 8'sd0) begin
      m4 = 8'sd59;
      h4 = h3 - 8'sd1;
    end else begin
      h4 = h3;
    end
    if (h4 < 8'sd0) begin
      h4 = 8'sd23;
    end
    s4 = s3;

    nxt.seconds = s4[5:0];
    nxt.minutes = m4[5:0];
    nxt.hours   = h4[4:0];
  end

endmodule

>>> src/scss_digit_mux.sv
// Segment pattern for the digit position being scanned.
module scss_digit_mux
  import scss_pkg::*;
(
  input  time_t      cur,
  input  logic [2:0] pos,
  output logic [7:0] segments
);

  logic [5:0] val;
  logic [2:0] tens;
  logic [5:0] units;
  logic       is_tens;

  // Split a value below 64 into tens and units
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  // Pick the field for this position
  always_comb begin
    val     = '0;
    is_tens = 1'b0;
    unique case (pos)
      PosHourTens: begin
        val = {1'b0, cur.hours};
        is_tens = 1'b1;
      end
      PosHourUnits: val = {1'b0, cur.hours};
      PosMinTens: begin
        val = cur.minutes;
        is_tens = 1'b1;
      end
      PosMinUnits: val = cur.minutes;
      PosSecTens: begin
        val = cur.seconds;
        is_tens = 1'b1;
      end
      PosSecUnits: val = cur.seconds;
      default: val = '0;
    endcase
  end

  assign tens  = tens_of(val);
  assign units = val - 6'({tens, 3'b000}) - 6'({tens, 1'b0});

  // Decode the digit, or show the separator point
  always_comb begin
    case (pos) inside
      PosHourTens, PosMinTens, PosSecTens,
      PosHourUnits, PosMinUnits, PosSecUnits:
        segments = digit_pattern(is_tens ? {1'b0, tens} : units[3:0]);
      default:
        segments = SeparatorPattern;
    endcase
  end

endmodule

>>> src/settable_clock_seven_segment_scan_top.sv
// Top level of the settable HH:MM:SS clock with multiplexed display scan.
//
// Each transfer on the input channel is one display-refresh tick carrying the
// four active-low buttons; each tick yields exactly one output transfer with
// the digit select, segment pattern and direction LED for the current scan
// position. One tick is taken every clock cycle unless the input stalls; the
// scan state, and the time on a sampling tick, update in the same cycle, and
// the result sits in a single output register. The input stalls only while
// that output register is full and its consumer stalls. ticks_per_second may
// be written at any idle time and takes effect on the next tick.
`include "assert_macros.svh"

module settable_clock_seven_segment_scan_top
  import scss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [TickWidth-1:0] cfg_wr_data
);

  logic [TickWidth-1:0] ticks_per_second;
  logic [TickWidth-1:0] tick_count;
  logic [TickWidth-1:0] tick_count_next;
  time_t                cur_time;
  time_t                time_next;
  logic                 adjust_down;
  logic                 adjust_down_next;
  logic [2:0]           scan_pos;
  logic [7:0]           seg;
  logic                 accept;
  logic                 sample;
  logic                 time_ok;

  // Stall only when the output register is full and held
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign sample = (tick_count == '0) || (tick_count >= ticks_per_second);
  assign tick_count_next = sample ? TickWidth'(1) : tick_count + TickWidth'(1);

  scss_time_step u_step (
    .cur              (cur_time),
    .adjust_down      (adjust_down),
    .btn              (in_data),
    .nxt              (time_next),
    .adjust_down_next (adjust_down_next)
  );

  scss_digit_mux u_mux (
    .cur      (cur_time),
    .pos      (scan_pos),
    .segments (seg)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TicksPerSecondReset;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  // Advance clock state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time    <= '0;
      adjust_down <= 1'b0;
      scan_pos    <= '0;
      tick_count  <= '0;
    end else if (accept) begin
      scan_pos   <= scan_pos + 3'd1;
      tick_count <= tick_count_next;
      if (sample) begin
        cur_time    <= time_next;
        adjust_down <= adjust_down_next;
      end
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.digit_select_n <= ~(8'b0000_0001 << scan_pos);
      out_data.segments       <= seg;
      out_data.direction_led  <= adjust_down;
    end
  end

  // Time of day stays within a day
  assign time_ok = (cur_time.hours <= HoursMax) && (cur_time.minutes <= MinutesMax) &&
                   (cur_time.seconds <= SecondsMax);

  `SCSS_ASSERT_ALWAYS(a_time_range, time_ok, "time of day out of range")
  `SCSS_ASSERT_IMPLIES(a_one_digit, out_valid, $countones(~out_data.digit_select_n) == 1, "digit select not one-hot")
  `SCSS_ASSERT_IMPLIES(a_stall_full, in_stall, out_valid, "input stalled with empty output")

endmodule

>>> verif/tb_top.sv
// Testbench for the settable clock with multiplexed seven-segment scan.
`timescale 1ns / 1ps

module tb_top;
  import scss_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned LongHoldCycles = 150;
  localparam int unsigned LongHoldAt = 400;
  localparam int unsigned NumPhases = 12;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [TickWidth-1:0] cfg_wr_data = '0;

  settable_clock_seven_segment_scan_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Tick stream waiting to be sent, and display frames the clock should show
  in_item_t  tick_queue[$];
  out_item_t expected_frames[$];

  // Shadow copy of the clock
  logic [TickWidth-1:0] sample_period = TicksPerSecondReset;
  logic [4:0]           clk_hours = '0;
  logic [5:0]           clk_minutes = '0;
  logic [5:0]           clk_seconds = '0;
  logic                 count_down = 1'b0;
  logic [2:0]           scan_pos = '0;
  logic [TickWidth-1:0] tick_count = '0;

  bit          tx_gaps_on = 1'b0;
  bit          rx_gaps_on = 1'b0;
  int unsigned n_frames = 0;
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Segment pattern for one decimal digit; blank beyond nine
  function automatic logic [7:0] digit_to_segments(input int unsigned v);
    logic [7:0] seg_table [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                   8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
    return (v < 10) ? seg_table[v] : 8'h00;
  endfunction

  // Show the current position, then on a sampling tick sample buttons and advance the time
  task automatic advance_clock(input in_item_t b);
    out_item_t f;
    int        h;
    int        m;
    int        s;
    int        step;
    f.digit_select_n = ~(8'd1 << scan_pos);
    f.direction_led  = count_down;
    case (scan_pos)
      PosHourTens:  f.segments = digit_to_segments(clk_hours / 10);
      PosHourUnits: f.segments = digit_to_segments(clk_hours % 10);
      PosMinTens:   f.segments = digit_to_segments(clk_minutes / 10);
      PosMinUnits:  f.segments = digit_to_segments(clk_minutes % 10);
      PosSecTens:   f.segments = digit_to_segments(clk_seconds / 10);
      PosSecUnits:  f.segments = digit_to_segments(clk_seconds % 10);
      default:      f.segments = SeparatorPattern;
    endcase
    expected_frames.push_back(f);
    scan_pos = scan_pos + 3'd1;

    if (tick_count == '0 || tick_count >= sample_period) begin
      tick_count = 1;
      h = clk_hours;
      m = clk_minutes;
      s = clk_seconds;
      if (!b.btn_direction_n) count_down = ~count_down;
      step = count_down ? -1 : 1;
      if (!b.btn_second_n) s += step;
      if (!b.btn_minute_n) m += step;
      if (!b.btn_hour_n) h += step;
      s += 1;
      // Overflow first, then underflow, each checked once
      if (s > 59) begin m += 1; s = 0; end
      if (m > 59) begin h += 1; m = 0; end
      if (h > 23) h = 0;
      if (s < 0) begin m -= 1; s = 59; end
      if (m < 0) begin h -= 1; m = 59; end
      if (h < 0) h = 23;
      clk_hours   = h[4:0];
      clk_minutes = m[5:0];
      clk_seconds = s[5:0];
    end else begin
      tick_count = tick_count + 1'b1;
    end
  endtask

  // Sender: present queued ticks, with a drawn gap after each transfer when gaps are on
  always @(posedge clk) begin : drive_ticks
    int unsigned gap_left;
    bit          busy;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        advance_clock(in_data);
        gap_left = tx_gaps_on ? $urandom_range(0, 16) : 0;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_queue.size() > 0) begin
          in_data <= tick_queue.pop_front();
          busy = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  // Receiver: check each frame, then stall for a drawn number of cycles when gaps are on
  always @(posedge clk) begin : check_frames
    int unsigned hold;
    out_item_t   want;
    if (rst) begin
      out_stall <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_frames++;
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected frame %h", $time, out_data);
          n_errors++;
        end else begin
          want = expected_frames.pop_front();
          if (out_data.digit_select_n !== want.digit_select_n) begin
            $display("%0t: digit_select_n expected %h actual %h", $time,
                     want.digit_select_n, out_data.digit_select_n);
            n_errors++;
          end
          if (out_data.segments !== want.segments) begin
            $display("%0t: segments expected %h actual %h", $time,
                     want.segments, out_data.segments);
            n_errors++;
          end
          if (out_data.direction_led !== want.direction_led) begin
            $display("%0t: direction_led expected %b actual %b", $time,
                     want.direction_led, out_data.direction_led);
            n_errors++;
          end
        end
        hold = rx_gaps_on ? $urandom_range(0, 16) : 0;
        // One long hold-off so the block backs up into its input
        if (n_frames == LongHoldAt) hold = LongHoldCycles;
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold != 0);
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_tick(input logic [3:0] buttons);
    tick_queue.push_back(in_item_t'(buttons));
  endtask

  // Hold until every tick is sent and every frame has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_period(input logic [TickWidth-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sample_period = v;
  endtask

  initial begin : stimulus
    int unsigned plan_period [NumPhases] = '{0, 2, 20, 3, 1, 4095, 6, 1, 2, 0, 1, 11};
    int unsigned plan_items [NumPhases] = '{100, 100, 30, 90, 150, 60, 90, 150, 100, 90,
                                            100, 70};
    int unsigned p_dir;
    int unsigned p_step;
    in_item_t    b;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset period: only the first tick samples; press everything at once
    queue_tick(4'b0000);
    queue_tick(4'b1111);
    queue_tick(4'b0000);
    queue_tick(4'b1111);
    wait_drained();

    // Every tick samples: each button alone, both directions, underflow
    write_period(1);
    queue_tick(4'b1111);
    queue_tick(4'b1011);
    queue_tick(4'b1101);
    queue_tick(4'b1110);
    queue_tick(4'b0111);
    queue_tick(4'b1011);
    queue_tick(4'b1101);
    queue_tick(4'b1110);
    queue_tick(4'b1110);
    queue_tick(4'b1000);
    queue_tick(4'b1000);
    queue_tick(4'b0000);
    queue_tick(4'b1000);
    queue_tick(4'b1011);
    queue_tick(4'b0111);
    queue_tick(4'b1111);
    wait_drained();

    // Random phases; period 20 then 3 lowers the register below the count
    for (int p = 0; p < NumPhases; p++) begin
      write_period(plan_period[p][TickWidth-1:0]);
      tx_gaps_on = (p % 3) != 0;
      rx_gaps_on = (p % 4) != 1;
      p_dir  = $urandom_range(5, 30);
      p_step = $urandom_range(10, 70);
      for (int i = 0; i < plan_items[p]; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          b = in_item_t'(4'($urandom_range(0, 15)));
        end else begin
          b.btn_direction_n = $urandom_range(0, 99) >= p_dir;
          b.btn_second_n    = $urandom_range(0, 99) >= p_step;
          b.btn_minute_n    = $urandom_range(0, 99) >= p_step;
          b.btn_hour_n      = $urandom_range(0, 99) >= p_step;
        end
        tick_queue.push_back(b);
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
